FILE: sv/tbsf_pkg.sv
// shared widths, register indexes, saturation limits and struct types
// for the two-body spring force unit; no dependencies
package tbsf_pkg;

    // fixed field widths
    localparam int COORD_W   = 32;
    localparam int MAG_W     = 32;
    localparam int LEN_W     = 33;
    localparam int SUM_W     = 65;
    localparam int KPROD_W   = COORD_W + LEN_W;
    localparam int WIDE_W    = 64;
    localparam int FORCE_W   = 48;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 2'd1;

    // register reset values
    localparam logic [COORD_W-1:0] STIFFNESS_RESET   = 32'h0001_0000;
    localparam logic [COORD_W-1:0] REST_LENGTH_RESET = 32'h0000_0000;

    // saturation limits
    localparam logic [FORCE_W-1:0] FORCE_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [FORCE_W-1:0] FORCE_MIN  = 48'h8000_0000_0000;
    localparam logic [FORCE_W-1:0] ENERGY_MAX = 48'hFFFF_FFFF_FFFF;

    // per-word flags from the front end
    typedef struct packed {
        logic a_mov;
        logic b_mov;
        logic neg_dx;
        logic neg_dy;
    } tbsf_flags_t;

    // control for force distribution
    typedef struct packed {
        logic a_mov;
        logic b_mov;
        logic neg_x;
        logic neg_y;
        logic zero_len;
    } tbsf_ctl_t;

    // one result word
    typedef struct packed {
        logic [FORCE_W-1:0] force_a_x;
        logic [FORCE_W-1:0] force_a_y;
        logic [FORCE_W-1:0] force_b_x;
        logic [FORCE_W-1:0] force_b_y;
        logic [FORCE_W-1:0] spring_energy;
    } tbsf_result_t;

endpackage

FILE: sv/tbsf_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on tbsf_pkg
module tbsf_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tbsf_pkg::SUM_W-1:0]   radicand,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [tbsf_pkg::LEN_W-1:0]   root,
    output logic [SIDE_W-1:0]            side_out
);
    import tbsf_pkg::*;

    localparam int STAGES = LEN_W;
    localparam int PAD_W  = 2 * LEN_W;
    localparam int REM_W  = LEN_W + 3;
    localparam int CMP_W  = REM_W + 2;

    logic [STAGES-1:0] vld_reg;
    logic [PAD_W-1:0]  rad_reg   [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [LEN_W-1:0]  root_reg  [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];
    logic [PAD_W-1:0]  rad_next  [STAGES];
    logic [REM_W-1:0]  rem_next  [STAGES];
    logic [LEN_W-1:0]  root_next [STAGES];

    // one trial subtract per stage, pairs taken from the top down
    always_comb
    begin
        logic [REM_W-1:0] r_in;
        logic [LEN_W-1:0] q_in;
        logic [PAD_W-1:0] d_in;
        logic [CMP_W-1:0] cur;
        logic [CMP_W-1:0] trial;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                r_in = '0;
                q_in = '0;
                d_in = PAD_W'(radicand);
            end
            else
            begin
                r_in = rem_reg[s-1];
                q_in = root_reg[s-1];
                d_in = rad_reg[s-1];
            end
            cur   = {r_in, d_in[2*(STAGES-1-s) +: 2]};
            trial = CMP_W'({q_in, 2'b01});
            rad_next[s] = d_in;
            if (cur >= trial)
            begin
                rem_next[s]  = REM_W'(cur - trial);
                root_next[s] = {q_in[LEN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = cur[REM_W-1:0];
                root_next[s] = {q_in[LEN_W-2:0], 1'b0};
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rad_reg[s]  <= rad_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                if (s == 0)
                begin
                    side_reg[s] <= side_in;
                end
                else
                begin
                    side_reg[s] <= side_reg[s-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: sv/tbsf_stretch.sv
// stretch, tension k*|x| and energy 0.5*k*x^2, seven register stages
// depends on tbsf_pkg
module tbsf_stretch #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  logic [tbsf_pkg::LEN_W-1:0]                len,
    input  logic [tbsf_pkg::COORD_W-1:0]              stiffness,
    input  logic [tbsf_pkg::COORD_W-1:0]              rest_length,
    input  logic [SIDE_W-1:0]                         side_in,
    output logic                                      out_valid,
    output logic                                      xneg,
    output logic [tbsf_pkg::KPROD_W-FRAC_BITS-1:0]    tension,
    output logic [tbsf_pkg::FORCE_W-1:0]              energy,
    output logic [SIDE_W-1:0]                         side_out
);
    import tbsf_pkg::*;

    localparam int STAGES  = 7;
    localparam int X_W     = LEN_W + 1;
    localparam int MX_W    = LEN_W;
    localparam int TEN_W   = KPROD_W - FRAC_BITS;
    localparam int SPLIT   = (MX_W + 1) / 2;
    localparam int SQL_W   = MX_W + SPLIT;
    localparam int SQH_W   = MX_W + MX_W - SPLIT;
    localparam int SQ_W    = 2 * MX_W;
    localparam int X2_W    = SQ_W - FRAC_BITS;
    localparam int X2H_W   = X2_W - COORD_W;
    localparam int EL_W    = 2 * COORD_W;
    localparam int EH_W    = COORD_W + X2H_W;
    localparam int EP_W    = COORD_W + X2_W;
    localparam int EN_SH   = FRAC_BITS + 1;
    localparam int ES_W    = EP_W - EN_SH;

    logic [STAGES-1:0] vld_reg;
    logic [SIDE_W-1:0] side_reg [STAGES];

    logic [X_W-1:0]    x_reg, x_next;
    logic [MX_W-1:0]   mx_reg, mx_next;
    logic              xneg2_reg, xneg3_reg, xneg4_reg, xneg5_reg, xneg6_reg, xneg7_reg;
    logic [KPROD_W-1:0] kp_reg, kp_next;
    logic [SQL_W-1:0]  sql_reg, sql_next;
    logic [SQH_W-1:0]  sqh_reg, sqh_next;
    logic [TEN_W-1:0]  ten4_reg, ten5_reg, ten6_reg, ten7_reg;
    logic [SQ_W-1:0]   sq_sum;
    logic [X2_W-1:0]   x2_reg, x2_next;
    logic [EL_W-1:0]   el_reg, el_next;
    logic [EH_W-1:0]   eh_reg, eh_next;
    logic [EP_W-1:0]   ep_reg, ep_next;
    logic [ES_W-1:0]   es;
    logic [FORCE_W-1:0] energy_reg, energy_next;

    // signed stretch and its magnitude
    assign x_next  = {1'b0, len} - {2'b00, rest_length};
    assign mx_next = x_reg[X_W-1] ? MX_W'(-x_reg) : x_reg[MX_W-1:0];

    // tension product and the two halves of the square
    assign kp_next  = KPROD_W'(stiffness) * KPROD_W'(mx_reg);
    assign sql_next = SQL_W'(mx_reg) * SQL_W'(mx_reg[SPLIT-1:0]);
    assign sqh_next = SQH_W'(mx_reg) * SQH_W'(mx_reg[MX_W-1:SPLIT]);

    // merge the square halves and drop fraction bits
    assign sq_sum  = SQ_W'(sql_reg) + (SQ_W'(sqh_reg) << SPLIT);
    assign x2_next = sq_sum[SQ_W-1:FRAC_BITS];

    // energy product in two partials
    assign el_next = EL_W'(stiffness) * EL_W'(x2_reg[COORD_W-1:0]);
    assign eh_next = EH_W'(stiffness) * EH_W'(x2_reg[X2_W-1:COORD_W]);
    assign ep_next = EP_W'(el_reg) + (EP_W'(eh_reg) << COORD_W);

    // halve, scale and clamp
    assign es          = ep_reg[EP_W-1:EN_SH];
    assign energy_next = (|es[ES_W-1:FORCE_W]) ? ENERGY_MAX : es[FORCE_W-1:0];

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                if (s == 0)
                begin
                    side_reg[s] <= side_in;
                end
                else
                begin
                    side_reg[s] <= side_reg[s-1];
                end
            end
            x_reg      <= x_next;
            mx_reg     <= mx_next;
            xneg2_reg  <= x_reg[X_W-1];
            kp_reg     <= kp_next;
            sql_reg    <= sql_next;
            sqh_reg    <= sqh_next;
            xneg3_reg  <= xneg2_reg;
            ten4_reg   <= kp_reg[KPROD_W-1:FRAC_BITS];
            x2_reg     <= x2_next;
            xneg4_reg  <= xneg3_reg;
            el_reg     <= el_next;
            eh_reg     <= eh_next;
            ten5_reg   <= ten4_reg;
            xneg5_reg  <= xneg4_reg;
            ep_reg     <= ep_next;
            ten6_reg   <= ten5_reg;
            xneg6_reg  <= xneg5_reg;
            energy_reg <= energy_next;
            ten7_reg   <= ten6_reg;
            xneg7_reg  <= xneg6_reg;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign xneg      = xneg7_reg;
    assign tension   = ten7_reg;
    assign energy    = energy_reg;
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: sv/tbsf_div.sv
// two-lane pipelined restoring divider with a shared divisor,
// one quotient bit per stage; depends on tbsf_pkg
module tbsf_div #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tbsf_pkg::MAG_W-1:0]   num_x,
    input  logic [tbsf_pkg::MAG_W-1:0]   num_y,
    input  logic [tbsf_pkg::LEN_W-1:0]   den,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [FRAC_BITS:0]           quo_x,
    output logic [FRAC_BITS:0]           quo_y,
    output logic [SIDE_W-1:0]            side_out
);
    import tbsf_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int DVD_W  = MAG_W + FRAC_BITS;
    localparam int CMP_W  = LEN_W + FRAC_BITS;

    logic [STAGES-1:0] vld_reg;
    logic [LEN_W-1:0]  den_reg   [STAGES];
    logic [DVD_W-1:0]  remx_reg  [STAGES];
    logic [DVD_W-1:0]  remy_reg  [STAGES];
    logic [Q_W-1:0]    qx_reg    [STAGES];
    logic [Q_W-1:0]    qy_reg    [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];
    logic [DVD_W-1:0]  remx_next [STAGES];
    logic [DVD_W-1:0]  remy_next [STAGES];
    logic [Q_W-1:0]    qx_next   [STAGES];
    logic [Q_W-1:0]    qy_next   [STAGES];
    logic [LEN_W-1:0]  den_next  [STAGES];

    // compare against the divisor shifted to this stage's quotient bit
    always_comb
    begin
        logic [DVD_W-1:0] rx_in;
        logic [DVD_W-1:0] ry_in;
        logic [Q_W-1:0]   qx_in;
        logic [Q_W-1:0]   qy_in;
        logic [LEN_W-1:0] d_in;
        logic [CMP_W-1:0] trial;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                rx_in = {num_x, {FRAC_BITS{1'b0}}};
                ry_in = {num_y, {FRAC_BITS{1'b0}}};
                qx_in = '0;
                qy_in = '0;
                d_in  = den;
            end
            else
            begin
                rx_in = remx_reg[s-1];
                ry_in = remy_reg[s-1];
                qx_in = qx_reg[s-1];
                qy_in = qy_reg[s-1];
                d_in  = den_reg[s-1];
            end
            trial       = CMP_W'(d_in) << (FRAC_BITS - s);
            den_next[s] = d_in;
            if (CMP_W'(rx_in) >= trial)
            begin
                remx_next[s] = DVD_W'(CMP_W'(rx_in) - trial);
                qx_next[s]   = qx_in | (Q_W'(1) << (FRAC_BITS - s));
            end
            else
            begin
                remx_next[s] = rx_in;
                qx_next[s]   = qx_in;
            end
            if (CMP_W'(ry_in) >= trial)
            begin
                remy_next[s] = DVD_W'(CMP_W'(ry_in) - trial);
                qy_next[s]   = qy_in | (Q_W'(1) << (FRAC_BITS - s));
            end
            else
            begin
                remy_next[s] = ry_in;
                qy_next[s]   = qy_in;
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            if (STAGES > 1)
            begin
                vld_reg <= {vld_reg[STAGES-2:0], in_valid};
            end
            else
            begin
                vld_reg <= STAGES'(in_valid);
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                den_reg[s]  <= den_next[s];
                remx_reg[s] <= remx_next[s];
                remy_reg[s] <= remy_next[s];
                qx_reg[s]   <= qx_next[s];
                qy_reg[s]   <= qy_next[s];
                if (s == 0)
                begin
                    side_reg[s] <= side_in;
                end
                else
                begin
                    side_reg[s] <= side_reg[s-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quo_x     = qx_reg[STAGES-1];
    assign quo_y     = qy_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: sv/tbsf_force.sv
// force scaling by the unit vector, distribution by the movable flags
// and saturation, three register stages; depends on tbsf_pkg
module tbsf_force #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  tbsf_pkg::tbsf_ctl_t                      ctl,
    input  logic [tbsf_pkg::KPROD_W-FRAC_BITS-1:0]   tension,
    input  logic [FRAC_BITS:0]                       quo_x,
    input  logic [FRAC_BITS:0]                       quo_y,
    input  logic [tbsf_pkg::FORCE_W-1:0]             energy,
    output logic                                     out_valid,
    output tbsf_pkg::tbsf_result_t                   result
);
    import tbsf_pkg::*;

    localparam int TEN_W = KPROD_W - FRAC_BITS;
    localparam int TH_W  = TEN_W - COORD_W;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int PL_W  = COORD_W + Q_W;
    localparam int PH_W  = TH_W + Q_W;
    localparam int FP_W  = TEN_W + Q_W;
    localparam int FM_W  = FP_W - FRAC_BITS;

    // saturate a signed magnitude to the force range
    function automatic logic [FORCE_W-1:0] sat_force(input logic neg,
                                                     input logic [FM_W-1:0] mag);
        logic [WIDE_W-1:0] m;
        m = WIDE_W'(mag);
        if (!neg)
        begin
            sat_force = (m > WIDE_W'(FORCE_MAX)) ? FORCE_MAX : m[FORCE_W-1:0];
        end
        else if (m >= WIDE_W'(FORCE_MIN))
        begin
            sat_force = FORCE_MIN;
        end
        else
        begin
            sat_force = FORCE_W'(0) - m[FORCE_W-1:0];
        end
    endfunction

    logic [2:0]         vld_reg;
    tbsf_ctl_t          ctl1_reg, ctl2_reg;
    logic [FORCE_W-1:0] en1_reg, en2_reg;
    logic [PL_W-1:0]    plx_reg, plx_next, ply_reg, ply_next;
    logic [PH_W-1:0]    phx_reg, phx_next, phy_reg, phy_next;
    logic [FP_W-1:0]    fpx, fpy;
    logic [FM_W-1:0]    fmx_reg, fmx_next, fmy_reg, fmy_next;
    tbsf_result_t       res_reg, res_next;

    // partial products of tension times unit vector
    assign plx_next = PL_W'(tension[COORD_W-1:0]) * PL_W'(quo_x);
    assign phx_next = PH_W'(tension[TEN_W-1:COORD_W]) * PH_W'(quo_x);
    assign ply_next = PL_W'(tension[COORD_W-1:0]) * PL_W'(quo_y);
    assign phy_next = PH_W'(tension[TEN_W-1:COORD_W]) * PH_W'(quo_y);

    // merge partials, zero-length axis gives no force
    assign fpx      = FP_W'(plx_reg) + (FP_W'(phx_reg) << COORD_W);
    assign fpy      = FP_W'(ply_reg) + (FP_W'(phy_reg) << COORD_W);
    assign fmx_next = ctl1_reg.zero_len ? '0 : fpx[FP_W-1:FRAC_BITS];
    assign fmy_next = ctl1_reg.zero_len ? '0 : fpy[FP_W-1:FRAC_BITS];

    // distribute by movable flags
    always_comb
    begin
        res_next.spring_energy = en2_reg;
        priority if (!ctl2_reg.a_mov)
        begin
            res_next.force_a_x = '0;
            res_next.force_a_y = '0;
            res_next.force_b_x = sat_force(ctl2_reg.neg_x, fmx_reg);
            res_next.force_b_y = sat_force(ctl2_reg.neg_y, fmy_reg);
        end
        else if (!ctl2_reg.b_mov)
        begin
            res_next.force_a_x = sat_force(!ctl2_reg.neg_x, fmx_reg);
            res_next.force_a_y = sat_force(!ctl2_reg.neg_y, fmy_reg);
            res_next.force_b_x = '0;
            res_next.force_b_y = '0;
        end
        else
        begin
            res_next.force_a_x = sat_force(!ctl2_reg.neg_x, fmx_reg >> 1);
            res_next.force_a_y = sat_force(!ctl2_reg.neg_y, fmy_reg >> 1);
            res_next.force_b_x = sat_force(ctl2_reg.neg_x, fmx_reg >> 1);
            res_next.force_b_y = sat_force(ctl2_reg.neg_y, fmy_reg >> 1);
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plx_reg  <= plx_next;
            phx_reg  <= phx_next;
            ply_reg  <= ply_next;
            phy_reg  <= phy_next;
            ctl1_reg <= ctl;
            en1_reg  <= energy;
            fmx_reg  <= fmx_next;
            fmy_reg  <= fmy_next;
            ctl2_reg <= ctl1_reg;
            en2_reg  <= en1_reg;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign result    = res_reg;

endmodule

FILE: sv/two_body_spring_force_unit.sv
// two-body hooke spring force unit, top level
// depends on tbsf_pkg, tbsf_sqrt, tbsf_stretch, tbsf_div, tbsf_force
//
// usage:
//   input channel (in_valid/in_ready) takes one word of two body positions
//   and movable flags; output channel (out_valid/out_ready) returns one word
//   of four saturated force components and the stored spring energy.
//   cfg channel writes stiffness (index 0) and rest_length (index 1);
//   cfg_ready is always high, other indexes are ignored. write only while idle.
// register stages: front end 4, square root 33 (one root bit per stage),
//   stretch and energy 7, divider FRAC_BITS + 1 (one quotient bit per
//   stage), force 3, output register 1.
// throughput: one word per cycle while skid is empty; all stages registered.
// reset: pipeline and output empty, stiffness = 1.0, rest_length = 0.
// stall: a two-entry output register/skid pair keeps the pipeline moving
//   one more word after out_ready drops; in_ready falls once the skid fills
//   and the whole pipeline holds until the skid drains. nothing is lost.
module two_body_spring_force_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [tbsf_pkg::COORD_W-1:0] pos_a_x,
    input  logic signed [tbsf_pkg::COORD_W-1:0] pos_a_y,
    input  logic signed [tbsf_pkg::COORD_W-1:0] pos_b_x,
    input  logic signed [tbsf_pkg::COORD_W-1:0] pos_b_y,
    input  logic                              a_movable,
    input  logic                              b_movable,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [tbsf_pkg::FORCE_W-1:0] force_a_x,
    output logic signed [tbsf_pkg::FORCE_W-1:0] force_a_y,
    output logic signed [tbsf_pkg::FORCE_W-1:0] force_b_x,
    output logic signed [tbsf_pkg::FORCE_W-1:0] force_b_y,
    output logic [tbsf_pkg::FORCE_W-1:0]      spring_energy,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbsf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbsf_pkg::COORD_W-1:0]      cfg_data
);
    import tbsf_pkg::*;

    localparam int D_W        = COORD_W + 1;
    localparam int SQX_W      = 2 * MAG_W;
    localparam int TEN_W      = KPROD_W - FRAC_BITS;
    localparam int FLAGS_W    = $bits(tbsf_flags_t);
    localparam int SQ_SIDE_W  = FLAGS_W + 2 * MAG_W;
    localparam int ST_SIDE_W  = SQ_SIDE_W + LEN_W;
    localparam int DV_SIDE_W  = $bits(tbsf_ctl_t) + TEN_W + FORCE_W;

    logic pipe_en;

    // configuration registers
    logic [COORD_W-1:0] stiffness_reg, rest_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= STIFFNESS_RESET;
            rest_length_reg <= REST_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STIFFNESS:   stiffness_reg   <= cfg_data;
                CFG_REST_LENGTH: rest_length_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // front end: axis, magnitudes, squares, sum
    logic [3:0]         fv_reg;
    logic [D_W-1:0]     dx_reg, dx_next, dy_reg, dy_next;
    logic               amov1_reg, bmov1_reg;
    logic [MAG_W-1:0]   mdx2_reg, mdx2_next, mdy2_reg, mdy2_next;
    logic [MAG_W-1:0]   mdx3_reg, mdy3_reg, mdx4_reg, mdy4_reg;
    tbsf_flags_t        fl2_reg, fl2_next, fl3_reg, fl4_reg;
    logic [SQX_W-1:0]   sxx_reg, sxx_next, syy_reg, syy_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;

    assign dx_next   = {pos_a_x[COORD_W-1], pos_a_x} - {pos_b_x[COORD_W-1], pos_b_x};
    assign dy_next   = {pos_a_y[COORD_W-1], pos_a_y} - {pos_b_y[COORD_W-1], pos_b_y};
    assign mdx2_next = dx_reg[D_W-1] ? MAG_W'(-dx_reg) : dx_reg[MAG_W-1:0];
    assign mdy2_next = dy_reg[D_W-1] ? MAG_W'(-dy_reg) : dy_reg[MAG_W-1:0];
    assign fl2_next  = '{a_mov: amov1_reg, b_mov: bmov1_reg,
                         neg_dx: dx_reg[D_W-1], neg_dy: dy_reg[D_W-1]};
    assign sxx_next  = SQX_W'(mdx2_reg) * SQX_W'(mdx2_reg);
    assign syy_next  = SQX_W'(mdy2_reg) * SQX_W'(mdy2_reg);
    assign sum_next  = SUM_W'(sxx_reg) + SUM_W'(syy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (pipe_en)
        begin
            fv_reg <= {fv_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            amov1_reg <= a_movable;
            bmov1_reg <= b_movable;
            mdx2_reg  <= mdx2_next;
            mdy2_reg  <= mdy2_next;
            fl2_reg   <= fl2_next;
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            mdx3_reg  <= mdx2_reg;
            mdy3_reg  <= mdy2_reg;
            fl3_reg   <= fl2_reg;
            sum_reg   <= sum_next;
            mdx4_reg  <= mdx3_reg;
            mdy4_reg  <= mdy3_reg;
            fl4_reg   <= fl3_reg;
        end
    end

    // axis length
    logic                 sq_valid;
    logic [LEN_W-1:0]     sq_root;
    logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;

    assign sq_side_in = {fl4_reg, mdx4_reg, mdy4_reg};

    tbsf_sqrt #(
        .SIDE_W   (SQ_SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (fv_reg[3]),
        .radicand (sum_reg),
        .side_in  (sq_side_in),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sq_side_out)
    );

    // stretch, tension, energy
    logic                 st_valid, st_xneg;
    logic [TEN_W-1:0]     st_tension;
    logic [FORCE_W-1:0]   st_energy;
    logic [ST_SIDE_W-1:0] st_side_in, st_side_out;
    tbsf_flags_t          st_flags;
    logic [MAG_W-1:0]     st_mdx, st_mdy;
    logic [LEN_W-1:0]     st_len;
    tbsf_ctl_t            st_ctl;

    assign st_side_in = {sq_side_out, sq_root};

    tbsf_stretch #(
        .FRAC_BITS  (FRAC_BITS),
        .SIDE_W     (ST_SIDE_W)
    ) u_stretch (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (sq_valid),
        .len        (sq_root),
        .stiffness  (stiffness_reg),
        .rest_length(rest_length_reg),
        .side_in    (st_side_in),
        .out_valid  (st_valid),
        .xneg       (st_xneg),
        .tension    (st_tension),
        .energy     (st_energy),
        .side_out   (st_side_out)
    );

    assign {st_flags, st_mdx, st_mdy, st_len} = st_side_out;
    assign st_ctl = '{a_mov: st_flags.a_mov, b_mov: st_flags.b_mov,
                      neg_x: st_xneg ^ st_flags.neg_dx,
                      neg_y: st_xneg ^ st_flags.neg_dy,
                      zero_len: (st_len == '0)};

    // unit vector
    logic                 dv_valid;
    logic [FRAC_BITS:0]   dv_qx, dv_qy;
    logic [DV_SIDE_W-1:0] dv_side_in, dv_side_out;
    tbsf_ctl_t            dv_ctl;
    logic [TEN_W-1:0]     dv_tension;
    logic [FORCE_W-1:0]   dv_energy;

    assign dv_side_in = {st_ctl, st_tension, st_energy};

    tbsf_div #(
        .FRAC_BITS(FRAC_BITS),
        .SIDE_W   (DV_SIDE_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (st_valid),
        .num_x    (st_mdx),
        .num_y    (st_mdy),
        .den      (st_len),
        .side_in  (dv_side_in),
        .out_valid(dv_valid),
        .quo_x    (dv_qx),
        .quo_y    (dv_qy),
        .side_out (dv_side_out)
    );

    assign {dv_ctl, dv_tension, dv_energy} = dv_side_out;

    // force scaling and distribution
    logic         fc_valid;
    tbsf_result_t fc_result;

    tbsf_force #(
        .FRAC_BITS(FRAC_BITS)
    ) u_force (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (dv_valid),
        .ctl      (dv_ctl),
        .tension  (dv_tension),
        .quo_x    (dv_qx),
        .quo_y    (dv_qy),
        .energy   (dv_energy),
        .out_valid(fc_valid),
        .result   (fc_result)
    );

    // output register with skid
    logic         out_valid_reg, skid_valid_reg, out_free;
    tbsf_result_t out_reg, skid_reg;

    assign pipe_en  = !skid_valid_reg;
    assign in_ready = pipe_en;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_free)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (fc_valid)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (fc_valid)
        begin
            if (out_free)
            begin
                out_reg <= fc_result;
            end
            else
            begin
                skid_reg <= fc_result;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign force_a_x     = out_reg.force_a_x;
    assign force_a_y     = out_reg.force_a_y;
    assign force_b_x     = out_reg.force_b_x;
    assign force_b_y     = out_reg.force_b_y;
    assign spring_energy = out_reg.spring_energy;

endmodule
